### rtl/cudf_pkg.sv
// Package for the card UID dedup filter: item and result types, opcode,
// status and card type codes, reset values and UID helper functions.
// No dependencies.
`timescale 1ns / 1ps

package cudf_pkg;

    localparam int MAX_UID_BYTES = 10;

    localparam logic [15:0] POLL_INTERVAL_RST = 16'd60;
    localparam logic [15:0] HOLD_RST          = 16'd500;
    localparam logic [15:0] REPEAT_WINDOW_RST = 16'd300;

    localparam logic [1:0] CFG_POLL_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_HOLD          = 2'd1;
    localparam logic [1:0] CFG_REPEAT_WINDOW = 2'd2;

    typedef enum logic [1:0] {
        OP_POLL   = 2'd0,
        OP_TAKE   = 2'd1,
        OP_IGNORE = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    localparam logic [2:0] ST_THROTTLED  = 3'd0;
    localparam logic [2:0] ST_NO_CARD    = 3'd1;
    localparam logic [2:0] ST_SUPPRESSED = 3'd2;
    localparam logic [2:0] ST_NEW_CARD   = 3'd3;
    localparam logic [2:0] ST_NONE_PEND  = 3'd4;
    localparam logic [2:0] ST_DELIVERED  = 3'd5;
    localparam logic [2:0] ST_IGN_ARMED  = 3'd6;

    localparam logic [3:0] CT_TAG_7B    = 4'd0;
    localparam logic [3:0] CT_SAK00_SH  = 4'd1;
    localparam logic [3:0] CT_CLASSIC1K = 4'd2;
    localparam logic [3:0] CT_MINI      = 4'd3;
    localparam logic [3:0] CT_CLASSIC4K = 4'd4;
    localparam logic [3:0] CT_PLUS2K    = 4'd5;
    localparam logic [3:0] CT_PLUS4K    = 4'd6;
    localparam logic [3:0] CT_ISO4      = 4'd7;
    localparam logic [3:0] CT_DF        = 4'd8;
    localparam logic [3:0] CT_UNKNOWN   = 4'd9;

    localparam logic [7:0] SAK_00 = 8'h00;
    localparam logic [7:0] SAK_08 = 8'h08;
    localparam logic [7:0] SAK_09 = 8'h09;
    localparam logic [7:0] SAK_18 = 8'h18;
    localparam logic [7:0] SAK_10 = 8'h10;
    localparam logic [7:0] SAK_11 = 8'h11;
    localparam logic [7:0] SAK_20 = 8'h20;
    localparam logic [7:0] SAK_28 = 8'h28;
    localparam logic [3:0] LONG_UID_LEN = 4'd7;

    typedef struct packed {
        logic [15:0] poll_interval;
        logic [15:0] hold;
        logic [15:0] repeat_window;
    } t_cfg;

    typedef struct packed {
        logic [63:0] low;
        logic [15:0] high;
        logic [3:0]  len;
    } t_uid;

    typedef struct packed {
        t_opcode     op;
        logic [31:0] now;
        logic        seen;
        t_uid        uid;
        logic [7:0]  sak;
        logic [31:0] dur;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        t_uid        uid;
        logic [3:0]  kind;
        logic [7:0]  sak;
    } t_result;

    function automatic logic [3:0] clamp_len(input logic [3:0] len);
        logic [3:0] max_len;
        max_len = 4'(MAX_UID_BYTES);
        return (len > max_len) ? max_len : len;
    endfunction

    function automatic logic [63:0] mask_low(input logic [63:0] v, input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (len > 4'(i)) m[63 - 8 * i -: 8] = v[63 - 8 * i -: 8];
        end
        return m;
    endfunction

    function automatic logic [15:0] mask_high(input logic [15:0] v, input logic [3:0] len);
        logic [15:0] m;
        m = '0;
        if (len >= 4'd9)  m[15:8] = v[15:8];
        if (len >= 4'd10) m[7:0]  = v[7:0];
        return m;
    endfunction

    function automatic logic [3:0] classify(input logic [7:0] sak, input logic [3:0] len);
        logic [3:0] t;
        unique case (sak)
            SAK_00:  t = (len >= LONG_UID_LEN) ? CT_TAG_7B : CT_SAK00_SH;
            SAK_08:  t = CT_CLASSIC1K;
            SAK_09:  t = CT_MINI;
            SAK_18:  t = CT_CLASSIC4K;
            SAK_10:  t = CT_PLUS2K;
            SAK_11:  t = CT_PLUS4K;
            SAK_20:  t = CT_ISO4;
            SAK_28:  t = CT_DF;
            default: t = CT_UNKNOWN;
        endcase
        return t;
    endfunction

endpackage

### rtl/card_uid_dedup_filter.sv
// Top level of the card UID dedup filter: input register, decision core,
// configuration registers and result register.
// Depends on cudf_pkg, cudf_cfg_regs, cudf_front and cudf_core.
//
// channel   direction  handshake               payload
// s (items) in         i_s_tvalid/o_s_tready   i_s_tdata 160b, i_s_tuser 3b
// m (result)out        o_m_tvalid/i_m_tready   o_m_tdata 96b,  o_m_tuser 3b
// cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index 2b, i_cfg_data 16b
//
// One item per cycle while the result side is not stalled; each item yields one
// result, passing through the input register, then the result register.
// Card state updates as an item moves from the input register to the result
// register, so consecutive items see each other's effects.
// A stalled result holds both registers; the input side stays ready while the
// input register is empty. Synchronous active-low reset clears all state and
// restores the configuration defaults; config writes are taken every cycle.
`timescale 1ns / 1ps

module card_uid_dedup_filter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // [31:0] now_ms, [95:32] uid_low, [111:96] uid_high, [115:112] uid_len,
    // [123:116] sak, [155:124] duration_ms, [159:156] zero
    input  logic [159:0]  i_s_tdata,
    // [1:0] opcode, [2] card_seen
    input  logic [2:0]    i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [63:0] uid_low_res, [79:64] uid_high_res, [83:80] uid_len_res,
    // [87:84] card kind, [95:88] sak_res
    output logic [95:0]   o_m_tdata,
    // [2:0] status
    output logic [2:0]    o_m_tuser,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);

    cudf_pkg::t_cfg    cfg;
    cudf_pkg::t_item   item;
    cudf_pkg::t_result result;
    logic              item_valid;
    logic              advance;
    logic              r_out_valid;
    cudf_pkg::t_result r_out;

    assign o_cfg_ready = 1'b1;
    assign advance     = item_valid && (!r_out_valid || i_m_tready);

    cudf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    cudf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_opcode   (i_s_tuser[1:0]),
        .i_now      (i_s_tdata[31:0]),
        .i_seen     (i_s_tuser[2]),
        .i_uid_low  (i_s_tdata[95:32]),
        .i_uid_high (i_s_tdata[111:96]),
        .i_uid_len  (i_s_tdata[115:112]),
        .i_sak      (i_s_tdata[123:116]),
        .i_dur      (i_s_tdata[155:124]),
        .i_advance  (advance),
        .o_valid    (item_valid),
        .o_item     (item)
    );

    cudf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_out <= result;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {r_out.sak, r_out.kind, r_out.uid.len,
                         r_out.uid.high, r_out.uid.low};

endmodule

### rtl/cudf_cfg_regs.sv
// Configuration registers of the card UID dedup filter.
// Depends on cudf_pkg.
`timescale 1ns / 1ps

module cudf_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [1:0]           i_index,
    input  logic [15:0]          i_data,
    output cudf_pkg::t_cfg       o_cfg
);

    cudf_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval <= cudf_pkg::POLL_INTERVAL_RST;
            r_cfg.hold          <= cudf_pkg::HOLD_RST;
            r_cfg.repeat_window <= cudf_pkg::REPEAT_WINDOW_RST;
        end else if (i_wr) begin
            unique case (i_index)
                cudf_pkg::CFG_POLL_INTERVAL: r_cfg.poll_interval <= i_data;
                cudf_pkg::CFG_HOLD:          r_cfg.hold          <= i_data;
                cudf_pkg::CFG_REPEAT_WINDOW: r_cfg.repeat_window <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/cudf_front.sv
// Input register of the card UID dedup filter: clamps the UID length and
// masks bytes beyond it as the item is captured. Depends on cudf_pkg.
`timescale 1ns / 1ps

module cudf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_opcode,
    input  logic [31:0]          i_now,
    input  logic                 i_seen,
    input  logic [63:0]          i_uid_low,
    input  logic [15:0]          i_uid_high,
    input  logic [3:0]           i_uid_len,
    input  logic [7:0]           i_sak,
    input  logic [31:0]          i_dur,
    input  logic                 i_advance,
    output logic                 o_valid,
    output cudf_pkg::t_item      o_item
);

    logic            r_valid;
    cudf_pkg::t_item r_item;
    cudf_pkg::t_item n_item;
    logic [3:0]      len_c;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        len_c           = cudf_pkg::clamp_len(i_uid_len);
        n_item.op       = cudf_pkg::t_opcode'(i_opcode);
        n_item.now      = i_now;
        n_item.seen     = i_seen;
        n_item.uid.low  = cudf_pkg::mask_low(i_uid_low, len_c);
        n_item.uid.high = cudf_pkg::mask_high(i_uid_high, len_c);
        n_item.uid.len  = len_c;
        n_item.sak      = i_sak;
        n_item.dur      = i_dur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/cudf_core.sv
// Decision logic and card state of the card UID dedup filter: throttle,
// hold, ignore, repeat window and pending slot. Depends on cudf_pkg.
`timescale 1ns / 1ps

module cudf_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  cudf_pkg::t_item      i_item,
    input  cudf_pkg::t_cfg       i_cfg,
    output cudf_pkg::t_result    o_result
);

    typedef struct packed {
        logic [31:0]    last_poll;
        logic           active;
        cudf_pkg::t_uid active_uid;
        logic [31:0]    last_seen;
        cudf_pkg::t_uid ign_uid;
        logic [31:0]    ign_until;
        cudf_pkg::t_uid rep_uid;
        logic [31:0]    rep_time;
        logic           pend_valid;
        cudf_pkg::t_uid pend_uid;
        logic [3:0]     pend_type;
        logic [7:0]     pend_sak;
    } t_state;

    t_state            r_st;
    t_state            n_st;
    cudf_pkg::t_result res_c;
    logic [31:0]       since_poll;
    logic [31:0]       since_seen;
    logic [31:0]       since_rep;
    logic              ign_expired;
    logic              ign_hit;
    logic              act_hit;
    logic              rep_hit;
    logic [3:0]        type_c;

    always_comb begin
        since_poll  = i_item.now - r_st.last_poll;
        since_seen  = i_item.now - r_st.last_seen;
        since_rep   = i_item.now - r_st.rep_time;
        ign_expired = (r_st.ign_until != '0) && (i_item.now > r_st.ign_until);
        ign_hit     = !ign_expired && (r_st.ign_uid.len != '0) &&
                      (i_item.now <= r_st.ign_until) && (i_item.uid == r_st.ign_uid);
        act_hit     = r_st.active && (i_item.uid == r_st.active_uid);
        rep_hit     = (i_item.uid == r_st.rep_uid) &&
                      (since_rep < {16'd0, i_cfg.repeat_window});
        type_c      = cudf_pkg::classify(i_item.sak, i_item.uid.len);

        n_st       = r_st;
        res_c      = '0;
        res_c.status = cudf_pkg::ST_THROTTLED;

        unique case (i_item.op)
            cudf_pkg::OP_TAKE: begin
                if (!r_st.pend_valid) begin
                    res_c.status = cudf_pkg::ST_NONE_PEND;
                end else begin
                    res_c.status    = cudf_pkg::ST_DELIVERED;
                    res_c.uid       = r_st.pend_uid;
                    res_c.kind      = r_st.pend_type;
                    res_c.sak       = r_st.pend_sak;
                    n_st.pend_valid = 1'b0;
                    n_st.pend_uid   = '0;
                    n_st.pend_type  = '0;
                    n_st.pend_sak   = '0;
                end
            end
            cudf_pkg::OP_IGNORE: begin
                n_st.ign_uid   = i_item.uid;
                n_st.ign_until = i_item.now + i_item.dur;
                res_c.status   = cudf_pkg::ST_IGN_ARMED;
            end
            cudf_pkg::OP_POLL: begin
                if (since_poll >= {16'd0, i_cfg.poll_interval}) begin
                    n_st.last_poll = i_item.now;
                    if (!i_item.seen) begin
                        res_c.status = cudf_pkg::ST_NO_CARD;
                        if (r_st.active && (since_seen > {16'd0, i_cfg.hold})) begin
                            n_st.active     = 1'b0;
                            n_st.active_uid = '0;
                        end
                    end else begin
                        n_st.last_seen = i_item.now;
                        res_c.status   = cudf_pkg::ST_SUPPRESSED;
                        if (ign_expired) begin
                            n_st.ign_uid   = '0;
                            n_st.ign_until = '0;
                        end
                        if (ign_hit || !act_hit) begin
                            n_st.active     = 1'b1;
                            n_st.active_uid = i_item.uid;
                        end
                        if (!ign_hit && !act_hit && !rep_hit) begin
                            n_st.rep_uid    = i_item.uid;
                            n_st.rep_time   = i_item.now;
                            n_st.pend_valid = 1'b1;
                            n_st.pend_uid   = i_item.uid;
                            n_st.pend_type  = type_c;
                            n_st.pend_sak   = i_item.sak;
                            res_c.status    = cudf_pkg::ST_NEW_CARD;
                            res_c.uid       = i_item.uid;
                            res_c.kind      = type_c;
                            res_c.sak       = i_item.sak;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_result = res_c;

endmodule

### rtl/cudf_checker.sv
// Port-level checks for the card UID dedup filter and the bind that
// attaches them to the top level. Depends on card_uid_dedup_filter, cudf_pkg.
`timescale 1ns / 1ps

module cudf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_s_tvalid,
    input logic          o_s_tready,
    input logic          o_m_tvalid,
    input logic          i_m_tready,
    input logic [95:0]   o_m_tdata,
    input logic [2:0]    o_m_tuser
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser <= cudf_pkg::ST_IGN_ARMED)
        else $error("status code out of range");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != cudf_pkg::ST_NEW_CARD &&
        o_m_tuser != cudf_pkg::ST_DELIVERED |-> o_m_tdata == '0)
        else $error("card fields set on a result without a card");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result register");

    a_item_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid |=> ##1 o_m_tvalid)
        else $error("accepted item did not produce a result");

endmodule

bind card_uid_dedup_filter cudf_checker u_cudf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### tb/tb_card_uid_dedup_filter.sv
// Self-checking testbench for card_uid_dedup_filter: directed and random polls, takes and
// ignore commands, each result compared with a debounce predictor kept in the bench.
// Depends on cudf_pkg and the card_uid_dedup_filter RTL.
`timescale 1ns / 1ps

module tb_card_uid_dedup_filter;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 6;
    localparam int PRINT_LIMIT    = 40;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_s_tvalid  = 1'b0;
    logic          o_s_tready;
    logic [159:0]  i_s_tdata   = '0;
    logic [2:0]    i_s_tuser   = '0;
    logic          o_m_tvalid;
    logic          i_m_tready  = 1'b0;
    logic [95:0]   o_m_tdata;
    logic [2:0]    o_m_tuser;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = '0;
    logic [15:0]   i_cfg_data  = '0;

    // predictor state
    logic [15:0] cfg_interval = cudf_pkg::POLL_INTERVAL_RST;
    logic [15:0] cfg_hold     = cudf_pkg::HOLD_RST;
    logic [15:0] cfg_repeat   = cudf_pkg::REPEAT_WINDOW_RST;
    logic [31:0] last_poll_ms = '0;
    logic [31:0] last_seen_ms = '0;
    logic [31:0] ignore_end_ms = '0;
    logic [31:0] report_ms    = '0;
    logic        act_on       = 1'b0;
    logic        pend_on      = 1'b0;
    cudf_pkg::t_uid act_uid   = '0;
    cudf_pkg::t_uid ign_uid   = '0;
    cudf_pkg::t_uid rep_uid   = '0;
    cudf_pkg::t_uid pend_uid  = '0;
    logic [3:0]  pend_type    = '0;
    logic [7:0]  pend_sak     = '0;

    cudf_pkg::t_result verdicts[$];
    int          mismatches   = 0;
    int          n_items      = 0;
    int          n_results    = 0;
    int          n_new_cards  = 0;
    int          n_cfg        = 0;
    int          idle_cycles  = 0;
    int          stall_left   = 0;
    bit          idling       = 1'b1;
    bit          s_driving    = 1'b0;
    logic [31:0] stamp        = '0;

    logic [63:0] pool_low  [POOL_SIZE];
    logic [15:0] pool_high [POOL_SIZE];
    logic [3:0]  pool_len  [POOL_SIZE];
    logic [7:0]  pool_sak  [POOL_SIZE];

    card_uid_dedup_filter uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [3:0] clamp_to_max(input logic [3:0] len);
        return (len > 4'(cudf_pkg::MAX_UID_BYTES)) ? 4'(cudf_pkg::MAX_UID_BYTES) : len;
    endfunction

    function automatic logic [63:0] keep_low(input logic [3:0] len);
        if (len >= 4'd8) return '1;
        return ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * len));
    endfunction

    function automatic logic [15:0] keep_high(input logic [3:0] len);
        if (len >= 4'd10) return 16'hFFFF;
        if (len == 4'd9) return 16'hFF00;
        return 16'h0000;
    endfunction

    function automatic logic [3:0] card_class(input logic [7:0] sak, input logic [3:0] len);
        case (sak)
            cudf_pkg::SAK_00:
                return (len >= cudf_pkg::LONG_UID_LEN) ? cudf_pkg::CT_TAG_7B
                                                       : cudf_pkg::CT_SAK00_SH;
            cudf_pkg::SAK_08: return cudf_pkg::CT_CLASSIC1K;
            cudf_pkg::SAK_09: return cudf_pkg::CT_MINI;
            cudf_pkg::SAK_18: return cudf_pkg::CT_CLASSIC4K;
            cudf_pkg::SAK_10: return cudf_pkg::CT_PLUS2K;
            cudf_pkg::SAK_11: return cudf_pkg::CT_PLUS4K;
            cudf_pkg::SAK_20: return cudf_pkg::CT_ISO4;
            cudf_pkg::SAK_28: return cudf_pkg::CT_DF;
            default:          return cudf_pkg::CT_UNKNOWN;
        endcase
    endfunction

    function automatic cudf_pkg::t_result judge_item(
            input cudf_pkg::t_opcode op, input logic [31:0] now,
            input logic seen, input logic [63:0] ul,
            input logic [15:0] uh, input logic [3:0] len_in,
            input logic [7:0] sak, input logic [31:0] dur);
        cudf_pkg::t_result v;
        cudf_pkg::t_uid    cur;
        logic [3:0]        len;
        v = '0;
        len = clamp_to_max(len_in);
        cur.low  = ul & keep_low(len);
        cur.high = uh & keep_high(len);
        cur.len  = len;
        case (op)
            cudf_pkg::OP_TAKE: begin
                if (!pend_on) begin
                    v.status = cudf_pkg::ST_NONE_PEND;
                end else begin
                    v.status  = cudf_pkg::ST_DELIVERED;
                    v.uid     = pend_uid;
                    v.kind    = pend_type;
                    v.sak     = pend_sak;
                    pend_on   = 1'b0;
                    pend_uid  = '0;
                    pend_type = '0;
                    pend_sak  = '0;
                end
            end
            cudf_pkg::OP_IGNORE: begin
                ign_uid       = cur;
                ignore_end_ms = now + dur;
                v.status      = cudf_pkg::ST_IGN_ARMED;
            end
            cudf_pkg::OP_POLL: begin
                if ((now - last_poll_ms) < {16'd0, cfg_interval}) begin
                    v.status = cudf_pkg::ST_THROTTLED;
                end else begin
                    last_poll_ms = now;
                    if (!seen) begin
                        if (act_on && (now - last_seen_ms) > {16'd0, cfg_hold}) begin
                            act_on  = 1'b0;
                            act_uid = '0;
                        end
                        v.status = cudf_pkg::ST_NO_CARD;
                    end else begin
                        last_seen_ms = now;
                        v.status = cudf_pkg::ST_SUPPRESSED;
                        if (ignore_end_ms != 0 && now > ignore_end_ms) begin
                            ign_uid       = '0;
                            ignore_end_ms = '0;
                        end
                        if (ign_uid.len != 0 && now <= ignore_end_ms && cur == ign_uid) begin
                            act_on  = 1'b1;
                            act_uid = cur;
                        end else if (!(act_on && cur == act_uid)) begin
                            act_on  = 1'b1;
                            act_uid = cur;
                            if (!(cur == rep_uid && (now - report_ms) < {16'd0, cfg_repeat}))
                            begin
                                rep_uid   = cur;
                                report_ms = now;
                                pend_on   = 1'b1;
                                pend_uid  = cur;
                                pend_type = card_class(sak, len);
                                pend_sak  = sak;
                                v.status  = cudf_pkg::ST_NEW_CARD;
                                v.uid     = cur;
                                v.kind    = pend_type;
                                v.sak     = sak;
                            end
                        end
                    end
                end
            end
            default: v.status = cudf_pkg::ST_THROTTLED;
        endcase
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s mismatch on result %0d: got %0h, want %0h",
                     $time, what, n_results, got, want);
    endtask

    // check each result against the oldest prediction; drive receiver stalls
    always @(posedge i_clk) begin
        cudf_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (verdicts.size() == 0) begin
                flag_mismatch("unpredicted result", 64'(o_m_tuser), 64'd0);
            end else begin
                want = verdicts.pop_front();
                if (o_m_tuser !== want.status)
                    flag_mismatch("status", 64'(o_m_tuser), 64'(want.status));
                if (o_m_tdata[63:0] !== want.uid.low)
                    flag_mismatch("uid_low", o_m_tdata[63:0], want.uid.low);
                if (o_m_tdata[79:64] !== want.uid.high)
                    flag_mismatch("uid_high", 64'(o_m_tdata[79:64]), 64'(want.uid.high));
                if (o_m_tdata[83:80] !== want.uid.len)
                    flag_mismatch("uid_len", 64'(o_m_tdata[83:80]), 64'(want.uid.len));
                if (o_m_tdata[87:84] !== want.kind)
                    flag_mismatch("kind", 64'(o_m_tdata[87:84]), 64'(want.kind));
                if (o_m_tdata[95:88] !== want.sak)
                    flag_mismatch("sak", 64'(o_m_tdata[95:88]), 64'(want.sak));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, verdicts.size());
                $display("FAIL card_uid_dedup_filter");
                $finish;
            end
        end
    end

    task automatic send_item(input cudf_pkg::t_opcode op, input logic [31:0] now,
                             input logic seen,
                             input logic [63:0] ul, input logic [15:0] uh,
                             input logic [3:0] len, input logic [7:0] sak,
                             input logic [31:0] dur);
        cudf_pkg::t_result v;
        if (idling && $urandom_range(0, 5) == 0) begin
            if (s_driving) begin
                i_s_tvalid <= 1'b0;
                s_driving = 1'b0;
            end
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        s_driving = 1'b1;
        i_s_tdata  <= {4'd0, dur, sak, len, uh, ul, now};
        i_s_tuser  <= {seen, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        v = judge_item(op, now, seen, ul, uh, len, sak, dur);
        if (v.status == cudf_pkg::ST_NEW_CARD) n_new_cards++;
        verdicts.push_back(v);
        n_items++;
    endtask

    task automatic wait_all_results;
        if (s_driving) begin
            i_s_tvalid <= 1'b0;
            s_driving = 1'b0;
        end
        while (verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        wait_all_results();
        repeat (3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            cudf_pkg::CFG_POLL_INTERVAL: cfg_interval = val;
            cudf_pkg::CFG_HOLD:          cfg_hold     = val;
            cudf_pkg::CFG_REPEAT_WINDOW: cfg_repeat   = val;
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic set_config(input logic [15:0] interval, input logic [15:0] hold,
                              input logic [15:0] rep);
        write_reg(cudf_pkg::CFG_POLL_INTERVAL, interval);
        write_reg(cudf_pkg::CFG_HOLD, hold);
        write_reg(cudf_pkg::CFG_REPEAT_WINDOW, rep);
    endtask

    task automatic refresh_pool;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_low[k]  = {$urandom, $urandom};
            pool_high[k] = 16'($urandom);
            case ($urandom_range(0, 3))
                0:       pool_len[k] = 4'd4;
                1:       pool_len[k] = 4'd7;
                2:       pool_len[k] = 4'd10;
                default: pool_len[k] = 4'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 8))
                0:       pool_sak[k] = cudf_pkg::SAK_00;
                1:       pool_sak[k] = cudf_pkg::SAK_08;
                2:       pool_sak[k] = cudf_pkg::SAK_09;
                3:       pool_sak[k] = cudf_pkg::SAK_18;
                4:       pool_sak[k] = cudf_pkg::SAK_10;
                5:       pool_sak[k] = cudf_pkg::SAK_11;
                6:       pool_sak[k] = cudf_pkg::SAK_20;
                7:       pool_sak[k] = cudf_pkg::SAK_28;
                default: pool_sak[k] = 8'($urandom);
            endcase
        end
    endtask

    task automatic test_reset_defaults;
        logic [63:0] ul;
        ul = {$urandom, $urandom};
        send_item(cudf_pkg::OP_TAKE, 32'd0, 1'b0, '0, '0, 4'd0, 8'd0, 32'd0);
        send_item(cudf_pkg::OP_POLL, 32'd10, 1'b0, '0, '0, 4'd0, 8'd0, 32'd0);
        send_item(cudf_pkg::OP_POLL, 32'd100, 1'b0, '0, '0, 4'd0, 8'd0, 32'd0);
        send_item(cudf_pkg::OP_POLL, 32'd200, 1'b1, ul, 16'hFFFF, 4'd4, cudf_pkg::SAK_08,
                  32'd0);
        send_item(cudf_pkg::OP_POLL, 32'd230, 1'b1, ul, 16'hFFFF, 4'd4, cudf_pkg::SAK_08,
                  32'd0);
        send_item(cudf_pkg::OP_POLL, 32'd300, 1'b1, ul, 16'h0000, 4'd4, cudf_pkg::SAK_08,
                  32'd0);
        send_item(cudf_pkg::OP_TAKE, 32'd310, 1'b0, '0, '0, 4'd0, 8'd0, 32'd0);
        send_item(cudf_pkg::OP_TAKE, 32'd320, 1'b0, '0, '0, 4'd0, 8'd0, 32'd0);
        send_item(cudf_pkg::OP_RSVD, 32'hFFFF_FFFF, 1'b1, '1, '1, 4'hF, 8'hFF,
                  32'hFFFF_FFFF);
        stamp = 32'd300;
    endtask

    task automatic test_card_types;
        logic [7:0] saks [11];
        logic [3:0] lens [11];
        saks = '{cudf_pkg::SAK_00, cudf_pkg::SAK_00, cudf_pkg::SAK_09, cudf_pkg::SAK_18,
                 cudf_pkg::SAK_10, cudf_pkg::SAK_11, cudf_pkg::SAK_20, cudf_pkg::SAK_28,
                 8'hFF, cudf_pkg::SAK_08, cudf_pkg::SAK_08};
        lens = '{4'd7, 4'd4, 4'd4, 4'd4, 4'd7, 4'd7, 4'd10, 4'd7, 4'd13, 4'd9, 4'd0};
        for (int k = 0; k < 11; k++) begin
            stamp += 32'd1000;
            send_item(cudf_pkg::OP_POLL, stamp, 1'b1, {$urandom, $urandom}, 16'($urandom),
                      lens[k], saks[k], 32'd0);
        end
        send_item(cudf_pkg::OP_TAKE, stamp, 1'b0, '0, '0, 4'd0, 8'd0, 32'd0);
    endtask

    task automatic test_ignore_rules;
        logic [63:0] ul_b;
        logic [63:0] ul_d;
        logic [63:0] ul_e;
        ul_b = {$urandom, $urandom};
        ul_d = {$urandom, $urandom};
        ul_e = {$urandom, $urandom};
        stamp += 32'd1000;
        send_item(cudf_pkg::OP_IGNORE, stamp, 1'b0, ul_b, 16'd0, 4'd7, 8'd0, 32'd5000);
        stamp += 32'd100;
        send_item(cudf_pkg::OP_POLL, stamp, 1'b1, ul_b, 16'd0, 4'd7, cudf_pkg::SAK_00,
                  32'd0);
        // zero-length ignore entry must not hide a zero-length card
        send_item(cudf_pkg::OP_IGNORE, stamp, 1'b0, '0, '0, 4'd0, 8'd0, 32'd100000);
        stamp += 32'd1000;
        send_item(cudf_pkg::OP_POLL, stamp, 1'b1, {$urandom, $urandom}, '1, 4'd0,
                  cudf_pkg::SAK_20, 32'd0);
        // expiry wraps past zero, so the entry is already stale
        send_item(cudf_pkg::OP_IGNORE, stamp, 1'b0, ul_d, 16'd0, 4'd4, 8'd0,
                  ~stamp + 32'd50);
        stamp += 32'd1000;
        send_item(cudf_pkg::OP_POLL, stamp, 1'b1, ul_d, 16'd0, 4'd4, cudf_pkg::SAK_09,
                  32'd0);
        // expiry lands exactly on zero, which reads as disarmed
        send_item(cudf_pkg::OP_IGNORE, stamp, 1'b0, ul_e, 16'hABCD, 4'd10, 8'd0,
                  32'd0 - stamp);
        stamp += 32'd1000;
        send_item(cudf_pkg::OP_POLL, stamp, 1'b1, ul_e, 16'hABCD, 4'd10, cudf_pkg::SAK_11,
                  32'd0);
        wait_all_results();
    endtask

    task automatic test_random_mix(input int count);
        int          r;
        int          k;
        logic [3:0]  clen;
        logic [31:0] span;
        logic [63:0] ul;
        logic [15:0] uh;
        logic [31:0] dur;
        refresh_pool();
        span = {16'd0, cfg_hold} + {16'd0, cfg_repeat} + 32'd50;
        for (int n = 0; n < count; n++) begin
            r    = $urandom_range(0, 99);
            k    = $urandom_range(0, POOL_SIZE - 1);
            clen = clamp_to_max(pool_len[k]);
            ul   = (pool_low[k] & keep_low(clen)) | ({$urandom, $urandom} & ~keep_low(clen));
            uh   = (pool_high[k] & keep_high(clen)) | (16'($urandom) & ~keep_high(clen));
            dur  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, span * 2);
            if (r < 72) begin
                if ($urandom_range(0, 4) == 0)
                    stamp = stamp + $urandom_range(0, cfg_interval);
                else
                    stamp = stamp + cfg_interval + $urandom_range(0, span);
            end
            if (r < 58)
                send_item(cudf_pkg::OP_POLL, stamp, 1'b1, ul, uh, pool_len[k],
                          ($urandom_range(0, 9) == 0) ? 8'($urandom) : pool_sak[k], dur);
            else if (r < 72)
                send_item(cudf_pkg::OP_POLL, stamp, 1'b0, {$urandom, $urandom},
                          16'($urandom), 4'($urandom), 8'($urandom), $urandom);
            else if (r < 87)
                send_item(cudf_pkg::OP_TAKE, $urandom, 1'($urandom), ul, uh, pool_len[k],
                          8'($urandom), $urandom);
            else if (r < 95)
                send_item(cudf_pkg::OP_IGNORE, stamp, 1'($urandom), ul, uh, pool_len[k],
                          8'($urandom), dur);
            else
                send_item(cudf_pkg::t_opcode'(2'($urandom)), $urandom, 1'($urandom),
                          {$urandom, $urandom}, 16'($urandom), 4'($urandom), 8'($urandom),
                          $urandom);
            if ($urandom_range(0, 149) == 0) wait_all_results();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_card_types();
        test_ignore_rules();

        set_config(16'($urandom_range(10, 200)), 16'($urandom_range(100, 1500)),
                   16'($urandom_range(100, 1500)));
        test_random_mix(300);

        set_config(16'd0, 16'd0, 16'd0);
        test_random_mix(150);

        stamp = 32'hFFF0_0000;
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_random_mix(150);

        stamp = 32'hFFFF_FC00;
        set_config(16'($urandom), 16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)));
        test_random_mix(300);

        set_config(cudf_pkg::POLL_INTERVAL_RST, cudf_pkg::HOLD_RST,
                   cudf_pkg::REPEAT_WINDOW_RST);
        wait_all_results();
        idling = 1'b0;
        test_random_mix(300);

        wait_all_results();
        repeat (8) @(posedge i_clk);
        $display("covered %0d items, %0d results, %0d new cards, %0d register writes",
                 n_items, n_results, n_new_cards, n_cfg);
        $display("register values: reset, all zero, full scale, random; timestamps wrapped");
        if (mismatches == 0)
            $display("PASS card_uid_dedup_filter");
        else
            $display("FAIL card_uid_dedup_filter");
        $finish;
    end

endmodule

### sim.f
rtl/cudf_pkg.sv
rtl/cudf_cfg_regs.sv
rtl/cudf_front.sv
rtl/cudf_core.sv
rtl/card_uid_dedup_filter.sv
rtl/cudf_checker.sv
tb/tb_card_uid_dedup_filter.sv
